@@ rtl/core/tbba_pkg.sv @@
// Shared constants, codes and types of the two-bit bitmap block allocator.
package tbba_pkg;

	localparam int NUM_GROUPS        = 4;
	localparam int ENTRIES_PER_GROUP = 4096;

	localparam int GRP_W      = (NUM_GROUPS > 1) ? $clog2(NUM_GROUPS) : 1;
	localparam int ENTRY_W    = $clog2(ENTRIES_PER_GROUP);
	localparam int MAP_WORD_W = 64;
	localparam int SLOTS      = MAP_WORD_W / 2;
	localparam int SLOT_W     = $clog2(SLOTS);
	localparam int WORDS      = ENTRIES_PER_GROUP / SLOTS;
	localparam int WORD_W     = ENTRY_W - SLOT_W;
	localparam int ADDR_W     = GRP_W + WORD_W;
	localparam int MAP_DEPTH  = NUM_GROUPS * WORDS;

	localparam int COUNT_W = 13;
	localparam int BASE_W  = 64;
	localparam int TOTAL_W = 32;

	localparam logic [1:0] OP_WRITE_ENTRY = 2'd0;
	localparam logic [1:0] OP_WRITE_DESC  = 2'd1;
	localparam logic [1:0] OP_ALLOC       = 2'd2;

	localparam logic [1:0] STATUS_OK      = 2'd0;
	localparam logic [1:0] STATUS_NOSPACE = 2'd1;
	localparam logic [1:0] STATUS_BROKEN  = 2'd2;
	localparam logic [1:0] STATUS_BADKIND = 2'd3;

	localparam logic [1:0] KIND_INODE = 2'd2;
	localparam logic [1:0] KIND_BAD   = 2'd3;

	localparam logic [1:0] ENTRY_FREE  = 2'd0;
	localparam logic [1:0] ENTRY_USED  = 2'd1;
	localparam logic [1:0] ENTRY_INODE = 2'd3;

	localparam logic [WORD_W-1:0] WORD_LAST = WORD_W'(WORDS - 1);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_ENTRY,
		ST_SCAN
	} state_t;

	// Lowest free slot of the word on the read port.
	typedef struct packed {
		logic              found;
		logic [SLOT_W-1:0] slot;
	} free_hit_t;

endpackage

@@ rtl/core/tbba_bitmap.sv @@
// Bitmap memory of two-bit entry states with its clearing pass and free-slot finder.
module tbba_bitmap (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  rd_en,
	input  logic [tbba_pkg::ADDR_W-1:0]           rd_addr,
	input  logic                                  wr_en,
	input  logic [tbba_pkg::ADDR_W-1:0]           wr_addr,
	input  logic [tbba_pkg::MAP_WORD_W-1:0]       wr_data,
	output logic [tbba_pkg::MAP_WORD_W-1:0]       rd_data,
	output tbba_pkg::free_hit_t                   hit,
	output logic                                  clearing
);

	logic [tbba_pkg::MAP_WORD_W-1:0] mem [tbba_pkg::MAP_DEPTH];
	logic [tbba_pkg::MAP_WORD_W-1:0] rd_data_q;
	logic [tbba_pkg::ADDR_W-1:0]     clr_addr_q;
	logic                            clearing_q;
	logic                            mem_we;
	logic [tbba_pkg::ADDR_W-1:0]     mem_wa;
	logic [tbba_pkg::MAP_WORD_W-1:0] mem_wd;

	// After reset every word is written to zero, one word per cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_addr_q <= '0;
			clearing_q <= 1'b1;
		end else if (clearing_q) begin
			clr_addr_q <= clr_addr_q + tbba_pkg::ADDR_W'(1);
			if (clr_addr_q == tbba_pkg::ADDR_W'(tbba_pkg::MAP_DEPTH - 1)) begin
				clearing_q <= 1'b0;
			end
		end
	end

	always_comb begin
		mem_we = clearing_q | wr_en;
		mem_wa = clearing_q ? clr_addr_q : wr_addr;
		mem_wd = clearing_q ? '0 : wr_data;
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= mem_wd;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	always_comb begin
		hit.found = 1'b0;
		hit.slot  = '0;
		for (int i = tbba_pkg::SLOTS - 1; i >= 0; i--) begin
			if (rd_data_q[2*i +: 2] == tbba_pkg::ENTRY_FREE) begin
				hit.found = 1'b1;
				hit.slot  = tbba_pkg::SLOT_W'(i);
			end
		end
	end

	assign rd_data  = rd_data_q;
	assign clearing = clearing_q;

endmodule

@@ rtl/core/two_bit_bitmap_block_allocator.sv @@
// Top level: first-fit block allocator over groups of two-bit entry bitmaps.
// Loads of a descriptor, out-of-range loads, unused opcodes and out-of-space allocations
// give their result in the cycle after the transfer; an entry load first writes its word back in ST_ENTRY.
// An allocation scans one 64-bit bitmap word (32 entries) per cycle through the single
// read port, with up to 128 word reads for a group of 4096 entries.
// The result is shown for one cycle with done high. After reset busy stays high while the
// 512 bitmap memory words are cleared one word per cycle.
module two_bit_bitmap_block_allocator (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  opcode,
	input  logic [1:0]  group_sel,
	input  logic [11:0] entry_index,
	input  logic [1:0]  entry_state,
	input  logic [12:0] free_count,
	input  logic [63:0] data_base,
	input  logic [12:0] valid_entries,
	input  logic [1:0]  alloc_kind,
	output logic        done,
	output logic [63:0] block_address,
	output logic [1:0]  status,
	output logic [1:0]  chosen_group,
	output logic [11:0] chosen_entry,
	output logic [12:0] free_after,
	output logic [31:0] total_allocated
);

	localparam int GW = tbba_pkg::GRP_W;
	localparam int EW = tbba_pkg::ENTRY_W;
	localparam int SW = tbba_pkg::SLOT_W;
	localparam int WW = tbba_pkg::WORD_W;
	localparam int AW = tbba_pkg::ADDR_W;
	localparam int CW = tbba_pkg::COUNT_W;
	localparam int BW = tbba_pkg::BASE_W;
	localparam int DW = tbba_pkg::MAP_WORD_W;

	tbba_pkg::state_t    state_q, state_d;
	tbba_pkg::free_hit_t hit;

	logic [CW-1:0] free_q  [tbba_pkg::NUM_GROUPS];
	logic [BW-1:0] base_q  [tbba_pkg::NUM_GROUPS];
	logic [CW-1:0] valid_q [tbba_pkg::NUM_GROUPS];
	logic [tbba_pkg::TOTAL_W-1:0] alloc_total_q;

	logic [GW-1:0] g_q;
	logic [SW-1:0] slot_q;
	logic [1:0]    es_q;
	logic [1:0]    kind_q;
	logic [AW-1:0] waddr_q;
	logic [WW-1:0] widx_q;
	logic [WW-1:0] rd_widx_q;

	logic          accept;
	logic          clearing;
	logic          gok;
	logic          eok;
	logic [GW-1:0] gsel;
	logic          any_free;
	logic [GW-1:0] pick;
	logic [EW-1:0] hit_entry;

	logic          rd_en;
	logic [AW-1:0] rd_addr;
	logic          wr_en;
	logic [AW-1:0] wr_addr;
	logic [DW-1:0] rd_data;
	logic [DW-1:0] patched;
	logic [SW-1:0] patch_slot;
	logic [1:0]    patch_val;

	logic          load_entry;
	logic          load_scan;
	logic          desc_we;
	logic          claim;
	logic          emit;
	logic [BW-1:0] res_addr;
	logic [1:0]    res_status;
	logic [1:0]    res_group;
	logic [EW-1:0] res_entry;
	logic [CW-1:0] res_free;

	logic          done_q;
	logic [BW-1:0] addr_q;
	logic [1:0]    status_q;
	logic [1:0]    group_q;
	logic [EW-1:0] entry_q;
	logic [CW-1:0] free_after_q;

	tbba_bitmap u_bitmap (
		.clk      (clk),
		.arst_n   (arst_n),
		.rd_en    (rd_en),
		.rd_addr  (rd_addr),
		.wr_en    (wr_en),
		.wr_addr  (wr_addr),
		.wr_data  (patched),
		.rd_data  (rd_data),
		.hit      (hit),
		.clearing (clearing)
	);

	assign busy   = clearing | (state_q != tbba_pkg::ST_IDLE);
	assign accept = start & ~busy;
	assign gsel   = group_sel[GW-1:0];
	assign gok    = 32'(group_sel) < tbba_pkg::NUM_GROUPS;
	assign eok    = 32'(entry_index) < tbba_pkg::ENTRIES_PER_GROUP;
	assign hit_entry = {rd_widx_q, hit.slot};

	// Lowest group with a non-zero free count.
	always_comb begin
		any_free = 1'b0;
		pick     = '0;
		for (int g = tbba_pkg::NUM_GROUPS - 1; g >= 0; g--) begin
			if (free_q[g] != '0) begin
				any_free = 1'b1;
				pick     = GW'(g);
			end
		end
	end

	// One two-bit slot of the word just read is replaced before write-back.
	always_comb begin
		patch_slot = (state_q == tbba_pkg::ST_SCAN) ? hit.slot : slot_q;
		patch_val  = (state_q == tbba_pkg::ST_SCAN) ?
			((kind_q == tbba_pkg::KIND_INODE) ? tbba_pkg::ENTRY_INODE : tbba_pkg::ENTRY_USED) :
			es_q;
		patched = rd_data;
		patched[{patch_slot, 1'b0} +: 2] = patch_val;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tbba_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		rd_en      = 1'b0;
		rd_addr    = '0;
		wr_en      = 1'b0;
		wr_addr    = '0;
		load_entry = 1'b0;
		load_scan  = 1'b0;
		desc_we    = 1'b0;
		claim      = 1'b0;
		emit       = 1'b0;
		res_addr   = '0;
		res_status = tbba_pkg::STATUS_OK;
		res_group  = '0;
		res_entry  = '0;
		res_free   = '0;
		case (state_q)
			tbba_pkg::ST_IDLE: begin
				if (accept) begin
					case (opcode)
						tbba_pkg::OP_WRITE_ENTRY: begin
							if (gok && eok) begin
								rd_en      = 1'b1;
								rd_addr    = {gsel, entry_index[EW-1:SW]};
								load_entry = 1'b1;
								state_d    = tbba_pkg::ST_ENTRY;
							end else begin
								emit      = 1'b1;
								res_group = group_sel;
								res_free  = gok ? free_q[gsel] : '0;
							end
						end
						tbba_pkg::OP_WRITE_DESC: begin
							desc_we   = gok;
							emit      = 1'b1;
							res_group = group_sel;
							res_free  = gok ? free_count : '0;
						end
						tbba_pkg::OP_ALLOC: begin
							if (any_free) begin
								rd_en     = 1'b1;
								rd_addr   = {pick, {WW{1'b0}}};
								load_scan = 1'b1;
								state_d   = tbba_pkg::ST_SCAN;
							end else begin
								emit       = 1'b1;
								res_status = tbba_pkg::STATUS_NOSPACE;
							end
						end
						default: begin
							emit = 1'b1;
						end
					endcase
				end
			end
			tbba_pkg::ST_ENTRY: begin
				wr_en     = 1'b1;
				wr_addr   = waddr_q;
				emit      = 1'b1;
				res_group = 2'(g_q);
				res_free  = free_q[g_q];
				state_d   = tbba_pkg::ST_IDLE;
			end
			tbba_pkg::ST_SCAN: begin
				res_group = 2'(g_q);
				res_free  = free_q[g_q];
				if (hit.found) begin
					emit      = 1'b1;
					res_entry = hit_entry;
					state_d   = tbba_pkg::ST_IDLE;
					if ({1'b0, hit_entry} >= valid_q[g_q]) begin
						res_status = tbba_pkg::STATUS_BROKEN;
					end else if (kind_q == tbba_pkg::KIND_BAD) begin
						res_status = tbba_pkg::STATUS_BADKIND;
					end else begin
						claim    = 1'b1;
						wr_en    = 1'b1;
						wr_addr  = {g_q, rd_widx_q};
						res_addr = base_q[g_q] + BW'(hit_entry);
						res_free = free_q[g_q] - CW'(1);
					end
				end else if (rd_widx_q == tbba_pkg::WORD_LAST) begin
					// The free count says space is left, but the bitmap has none.
					emit       = 1'b1;
					res_status = tbba_pkg::STATUS_BROKEN;
					state_d    = tbba_pkg::ST_IDLE;
				end else begin
					rd_en   = 1'b1;
					rd_addr = {g_q, widx_q};
				end
			end
			default: begin
				state_d = tbba_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (load_entry) begin
			g_q     <= gsel;
			slot_q  <= entry_index[SW-1:0];
			es_q    <= entry_state;
			waddr_q <= rd_addr;
		end
		if (load_scan) begin
			g_q       <= pick;
			kind_q    <= alloc_kind;
			widx_q    <= WW'(1);
			rd_widx_q <= '0;
		end else if (state_q == tbba_pkg::ST_SCAN) begin
			widx_q    <= widx_q + WW'(1);
			rd_widx_q <= widx_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int g = 0; g < tbba_pkg::NUM_GROUPS; g++) begin
				free_q[g]  <= '0;
				base_q[g]  <= '0;
				valid_q[g] <= '0;
			end
			alloc_total_q <= '0;
		end else begin
			if (desc_we) begin
				free_q[gsel]  <= free_count;
				base_q[gsel]  <= data_base;
				valid_q[gsel] <= valid_entries;
			end
			if (claim) begin
				free_q[g_q]   <= free_q[g_q] - CW'(1);
				alloc_total_q <= alloc_total_q + tbba_pkg::TOTAL_W'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= emit;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			addr_q       <= res_addr;
			status_q     <= res_status;
			group_q      <= res_group;
			entry_q      <= res_entry;
			free_after_q <= res_free;
		end
	end

	assign done            = done_q;
	assign block_address   = addr_q;
	assign status          = status_q;
	assign chosen_group    = group_q;
	assign chosen_entry    = entry_q;
	assign free_after      = free_after_q;
	assign total_allocated = alloc_total_q;

endmodule

@@ tb/two_bit_bitmap_block_allocator_tb.sv @@
// Self-checking testbench for the two-bit bitmap block allocator.
module two_bit_bitmap_block_allocator_tb;
	import tbba_pkg::*;

	localparam logic [1:0] OP_UNUSED = 2'd3;
	localparam logic [1:0] KIND_DATA = 2'd0;
	localparam logic [1:0] KIND_META = 2'd1;
	localparam logic [1:0] ENTRY_UNLINKED = 2'd2;
	localparam int RANDOM_ITEMS = 560;
	localparam int FILL_ENTRIES = 160;
	localparam int SETTLE_CYCLES = 300;

	typedef struct packed {
		logic [1:0]  opcode;
		logic [1:0]  group_sel;
		logic [11:0] entry_index;
		logic [1:0]  entry_state;
		logic [12:0] free_count;
		logic [63:0] data_base;
		logic [12:0] valid_entries;
		logic [1:0]  alloc_kind;
	} request_t;

	typedef struct packed {
		logic [63:0] block_address;
		logic [1:0]  status;
		logic [1:0]  chosen_group;
		logic [11:0] chosen_entry;
		logic [12:0] free_after;
		logic [31:0] total_allocated;
	} outcome_t;

	logic clk = 1'b0;
	logic arst_n;
	logic start;
	logic busy;
	logic [1:0]  opcode;
	logic [1:0]  group_sel;
	logic [11:0] entry_index;
	logic [1:0]  entry_state;
	logic [12:0] free_count;
	logic [63:0] data_base;
	logic [12:0] valid_entries;
	logic [1:0]  alloc_kind;
	logic        done;
	logic [63:0] block_address;
	logic [1:0]  status;
	logic [1:0]  chosen_group;
	logic [11:0] chosen_entry;
	logic [12:0] free_after;
	logic [31:0] total_allocated;

	// Mirror of the allocator state, updated in transfer order.
	bit [1:0]         map_state [NUM_GROUPS*ENTRIES_PER_GROUP];
	bit [COUNT_W-1:0] grp_free [NUM_GROUPS];
	bit [BASE_W-1:0]  grp_base [NUM_GROUPS];
	bit [COUNT_W-1:0] grp_valid [NUM_GROUPS];
	bit [COUNT_W-1:0] grp_inodes [NUM_GROUPS];
	bit [TOTAL_W-1:0] alloc_count;
	bit [TOTAL_W-1:0] inode_count;

	outcome_t pending_outcomes[$];
	int mismatches = 0;
	bit gaps_on = 1'b1;

	two_bit_bitmap_block_allocator dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.opcode(opcode),
		.group_sel(group_sel),
		.entry_index(entry_index),
		.entry_state(entry_state),
		.free_count(free_count),
		.data_base(data_base),
		.valid_entries(valid_entries),
		.alloc_kind(alloc_kind),
		.done(done),
		.block_address(block_address),
		.status(status),
		.chosen_group(chosen_group),
		.chosen_entry(chosen_entry),
		.free_after(free_after),
		.total_allocated(total_allocated)
	);

	always #1 clk = ~clk;

	function automatic outcome_t apply_request(input request_t r);
		outcome_t o;
		int g;
		int e;
		bit found;
		o = '0;
		found = 1'b0;
		case (r.opcode)
			OP_WRITE_ENTRY, OP_WRITE_DESC: begin
				if (r.group_sel < NUM_GROUPS) begin
					if (r.opcode == OP_WRITE_DESC) begin
						grp_free[r.group_sel] = r.free_count;
						grp_base[r.group_sel] = r.data_base;
						grp_valid[r.group_sel] = r.valid_entries;
					end else if (r.entry_index < ENTRIES_PER_GROUP) begin
						map_state[r.group_sel*ENTRIES_PER_GROUP + r.entry_index] = r.entry_state;
					end
					o.free_after = grp_free[r.group_sel];
				end
				o.chosen_group = r.group_sel;
			end
			OP_ALLOC: begin
				g = 0;
				while (g < NUM_GROUPS && grp_free[g] == 0)
					g++;
				if (g == NUM_GROUPS) begin
					o.status = STATUS_NOSPACE;
				end else begin
					e = 0;
					while (!found && e < ENTRIES_PER_GROUP) begin
						if (map_state[g*ENTRIES_PER_GROUP + e] == ENTRY_FREE)
							found = 1'b1;
						else
							e++;
					end
					o.chosen_group = 2'(g);
					o.free_after = grp_free[g];
					if (!found) begin
						o.status = STATUS_BROKEN;
					end else if (e >= grp_valid[g]) begin
						o.status = STATUS_BROKEN;
						o.chosen_entry = 12'(e);
					end else if (r.alloc_kind == KIND_BAD) begin
						o.status = STATUS_BADKIND;
						o.chosen_entry = 12'(e);
					end else begin
						if (r.alloc_kind == KIND_INODE) begin
							map_state[g*ENTRIES_PER_GROUP + e] = ENTRY_INODE;
							grp_inodes[g] = grp_inodes[g] + 1'b1;
							inode_count = inode_count + 1'b1;
						end else begin
							map_state[g*ENTRIES_PER_GROUP + e] = ENTRY_USED;
						end
						grp_free[g] = grp_free[g] - 1'b1;
						alloc_count = alloc_count + 1'b1;
						o.status = STATUS_OK;
						o.block_address = grp_base[g] + 64'(e);
						o.chosen_entry = 12'(e);
						o.free_after = grp_free[g];
					end
				end
			end
			default: ;
		endcase
		o.total_allocated = alloc_count;
		return o;
	endfunction

	function automatic request_t random_request();
		request_t r;
		r.opcode = 2'($urandom_range(0, 3));
		r.group_sel = 2'($urandom);
		r.entry_index = 12'($urandom);
		r.entry_state = 2'($urandom);
		r.free_count = 13'($urandom_range(0, 4096));
		r.data_base = {$urandom, $urandom};
		r.valid_entries = 13'($urandom_range(0, 4096));
		r.alloc_kind = 2'($urandom);
		return r;
	endfunction

	function automatic request_t desc_req(input logic [1:0] g, input logic [12:0] cnt,
			input logic [63:0] base, input logic [12:0] valid);
		request_t r;
		r = random_request();
		r.opcode = OP_WRITE_DESC;
		r.group_sel = g;
		r.free_count = cnt;
		r.data_base = base;
		r.valid_entries = valid;
		return r;
	endfunction

	function automatic request_t entry_req(input logic [1:0] g, input logic [11:0] idx,
			input logic [1:0] st);
		request_t r;
		r = random_request();
		r.opcode = OP_WRITE_ENTRY;
		r.group_sel = g;
		r.entry_index = idx;
		r.entry_state = st;
		return r;
	endfunction

	function automatic request_t alloc_req(input logic [1:0] kind);
		request_t r;
		r = random_request();
		r.opcode = OP_ALLOC;
		r.alloc_kind = kind;
		return r;
	endfunction

	// Mostly small counts so groups run dry often, with the extremes mixed in.
	function automatic logic [12:0] pick_count(input int small_hi);
		case ($urandom_range(0, 9))
			0: return 13'd0;
			1: return 13'd4096;
			2: return 13'($urandom_range(0, 4096));
			default: return 13'($urandom_range(1, small_hi));
		endcase
	endfunction

	function automatic logic [1:0] pick_kind();
		if ($urandom_range(0, 99) < 8)
			return KIND_BAD;
		return 2'($urandom_range(0, 2));
	endfunction

	// Drives one item from a falling edge and holds it until the transfer happens.
	task automatic send_item(input request_t r);
		int gap;
		if (gaps_on && $urandom_range(0, 99) < 35) begin
			gap = $urandom_range(1, 4);
			@(negedge clk);
			start <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		start <= 1'b1;
		opcode <= r.opcode;
		group_sel <= r.group_sel;
		entry_index <= r.entry_index;
		entry_state <= r.entry_state;
		free_count <= r.free_count;
		data_base <= r.data_base;
		valid_entries <= r.valid_entries;
		alloc_kind <= r.alloc_kind;
		do
			@(posedge clk);
		while (busy);
		pending_outcomes.push_back(apply_request(r));
	endtask

	task automatic wait_all_results();
		@(negedge clk);
		start <= 1'b0;
		while (pending_outcomes.size() != 0)
			@(posedge clk);
	endtask

	task automatic check_field(input string name, input logic [63:0] want,
			input logic [63:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
			mismatches++;
		end
	endtask

	always @(posedge clk) begin
		outcome_t want;
		if (arst_n && done) begin
			if (pending_outcomes.size() == 0) begin
				$display("%0t: unexpected result, expected none, actual status %0d address %0h",
					$time, status, block_address);
				mismatches++;
			end else begin
				want = pending_outcomes.pop_front();
				check_field("block_address", want.block_address, block_address);
				check_field("status", 64'(want.status), 64'(status));
				check_field("chosen_group", 64'(want.chosen_group), 64'(chosen_group));
				check_field("chosen_entry", 64'(want.chosen_entry), 64'(chosen_entry));
				check_field("free_after", 64'(want.free_after), 64'(free_after));
				check_field("total_allocated", 64'(want.total_allocated),
					64'(total_allocated));
			end
		end
	end

	task automatic test_empty_and_unused();
		request_t r;
		send_item(alloc_req(KIND_DATA));
		r = random_request();
		r.opcode = OP_UNUSED;
		send_item(r);
		send_item(alloc_req(KIND_INODE));
	endtask

	task automatic test_descriptor_checks();
		// Zero valid entries makes even entry zero lie past the end of the group.
		send_item(desc_req(2'd0, 13'd4096, '1, 13'd0));
		send_item(alloc_req(KIND_META));
		send_item(desc_req(2'd0, 13'd4096, '1, 13'd4096));
		send_item(alloc_req(KIND_BAD));
		send_item(alloc_req(KIND_DATA));
		// The base plus entry one wraps the address to zero.
		send_item(alloc_req(KIND_INODE));
		send_item(entry_req(2'd0, 12'd4095, ENTRY_INODE));
		send_item(entry_req(2'd3, 12'd0, ENTRY_UNLINKED));
		send_item(entry_req(2'd0, 12'd2, ENTRY_UNLINKED));
		send_item(alloc_req(KIND_META));
		wait_all_results();
	endtask

	task automatic test_group_order();
		send_item(desc_req(2'd0, 13'd0, {$urandom, $urandom}, 13'd4096));
		send_item(desc_req(2'd1, 13'd1, {$urandom, $urandom}, 13'd1));
		send_item(alloc_req(KIND_DATA));
		send_item(alloc_req(KIND_DATA));
		send_item(desc_req(2'd2, 13'd1, {$urandom, $urandom}, 13'd4096));
		send_item(entry_req(2'd2, 12'd0, ENTRY_USED));
		send_item(alloc_req(KIND_INODE));
		wait_all_results();
	endtask

	// Fills the first words of group three, then frees only the last filled entry.
	task automatic test_full_group();
		logic [63:0] base;
		base = {$urandom, $urandom};
		gaps_on = 1'b0;
		for (int g = 0; g < 3; g++)
			send_item(desc_req(2'(g), 13'd0, {$urandom, $urandom}, 13'd4096));
		for (int i = 0; i < FILL_ENTRIES; i++)
			send_item(entry_req(2'd3, 12'(i), 2'($urandom_range(1, 3))));
		send_item(desc_req(2'd3, 13'd5, base, 13'd4096));
		send_item(alloc_req(KIND_DATA));
		send_item(entry_req(2'd3, 12'(FILL_ENTRIES - 1), ENTRY_FREE));
		send_item(desc_req(2'd3, 13'd5, base, 13'(FILL_ENTRIES - 1)));
		send_item(alloc_req(KIND_DATA));
		send_item(desc_req(2'd3, 13'd5, base, 13'd4096));
		send_item(alloc_req(KIND_INODE));
		wait_all_results();
		gaps_on = 1'b1;
	endtask

	task automatic test_random_traffic();
		int sent;
		int burst;
		logic [1:0] g;
		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			gaps_on = !(sent >= 250 && sent < 400);
			case ($urandom_range(0, 19))
				0, 1, 2, 3, 4, 5: begin
					send_item(desc_req(2'($urandom), pick_count(40), {$urandom, $urandom},
						pick_count(300)));
					burst = $urandom_range(2, 10);
					repeat (burst) send_item(alloc_req(pick_kind()));
					sent += burst + 1;
				end
				6, 7, 8, 9: begin
					g = 2'($urandom);
					burst = $urandom_range(1, 4);
					repeat (burst) begin
						if ($urandom_range(0, 3) == 0)
							send_item(entry_req(g, 12'($urandom), 2'($urandom)));
						else
							send_item(entry_req(g, 12'($urandom_range(0, 255)),
								($urandom_range(0, 9) < 4) ? ENTRY_FREE : 2'($urandom)));
					end
					send_item(alloc_req(pick_kind()));
					sent += burst + 1;
				end
				10, 11, 12, 13, 14, 15, 16: begin
					burst = $urandom_range(1, 6);
					repeat (burst) send_item(alloc_req(pick_kind()));
					sent += burst;
				end
				17, 18: begin
					send_item(random_request());
					sent++;
				end
				default: wait_all_results();
			endcase
		end
		gaps_on = 1'b1;
	endtask

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		opcode = OP_WRITE_ENTRY;
		group_sel = '0;
		entry_index = '0;
		entry_state = '0;
		free_count = '0;
		data_base = '0;
		valid_entries = '0;
		alloc_kind = '0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_empty_and_unused();
		test_descriptor_checks();
		test_group_order();
		test_full_group();
		test_random_traffic();

		wait_all_results();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatches == 0 && pending_outcomes.size() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

	initial begin
		#2000000;
		$display("[FAIL] regression broken");
		$finish;
	end

endmodule
